@@ rtl/rml_pkg.sv @@
// Package for the read mark list block: field widths, request codes,
// register indexes and the controller state type.
// No dependencies; every other file of the block imports it.
`default_nettype none

package rml_pkg;

  // Field widths fixed by the request and result formats.
  localparam int RML_STAMP_W = 32;
  localparam int RML_TYPE_W  = 2;
  localparam int RML_COUNT_W = 7;

  // Configuration port: two 32-bit registers at byte addresses 0 and 4.
  localparam int RML_ADDR_W = 3;
  localparam int RML_DATA_W = 32;

  localparam logic REG_EXPIRE = 1'b0;
  localparam logic REG_ENABLE = 1'b1;

  // Request codes carried in req_type.
  localparam logic [RML_TYPE_W-1:0] REQ_MARK  = 2'd0;
  localparam logic [RML_TYPE_W-1:0] REQ_QUERY = 2'd1;
  localparam logic [RML_TYPE_W-1:0] REQ_TRUNC = 2'd2;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_DONE
  } rml_state_t;

endpackage : rml_pkg

`default_nettype wire

@@ rtl/rml_if.sv @@
// Handshake interfaces for the request and result channels of the block.
// Depends on rml_pkg for the field widths.
`default_nettype none

interface rml_req_if import rml_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [RML_TYPE_W-1:0]         req_type;
  logic signed [RML_STAMP_W-1:0] post_time;

  modport source (output valid, output req_type, output post_time, input ready);
  modport sink (input valid, input req_type, input post_time, output ready);
endinterface : rml_req_if

interface rml_rsp_if import rml_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   unread;
  logic                   list_changed;
  logic [RML_COUNT_W-1:0] mark_count;

  modport source (output valid, output unread, output list_changed, output mark_count,
                  input ready);
  modport sink (input valid, input unread, input list_changed, input mark_count,
                output ready);
endinterface : rml_rsp_if

`default_nettype wire

@@ rtl/read_mark_list_core.sv @@
// Read mark list: a descending list of read timestamps held in one memory.
// Depends on rml_pkg and the rml_req_if / rml_rsp_if interfaces.
//
// Usage:
//   A request beat on req carries req_type (mark, query, truncate) and a
//   signed post_time. Every request gives exactly one result beat on rsp:
//   unread (queries only), list_changed and mark_count after the request.
//   The user writes expire_time (address 0) and marking_enabled (address 4)
//   registers via APB only while idle (not enforced); pready is always 1.
// Timing:
//   One request is in flight at a time; req.ready is high only when idle.
//   A request with no list walk goes through ST_DONE to the result register.
//   Marks and queries on a non-empty list read one stored stamp per cycle
//   through the memory's single read port and stop at the deciding entry;
//   an insert walks to the end, shifting the tail, and a growing list
//   passes through ST_TAIL before ST_DONE. Once the result is registered,
//   the block returns to idle and takes the next request.
// Reset and stall:
//   Reset empties the list, clears the dirty flag and both registers. The
//   memory itself is not cleared; entries past the count are never read.
//   The result sits in an output register; the block takes the next
//   request while it waits, and holds a finished result until it drains.
`default_nettype none

module read_mark_list_core import rml_pkg::*; #(
  parameter int MAX_MARKS = 80
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  rml_req_if.sink                    req,
  rml_rsp_if.source                  rsp,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [RML_ADDR_W-1:0] paddr,
  input  wire logic [RML_DATA_W-1:0] pwdata,
  output logic      [RML_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int AW = (MAX_MARKS > 1) ? $clog2(MAX_MARKS) : 1;
  localparam int CW = $clog2(MAX_MARKS + 1);

  // Configuration registers.
  logic signed [RML_STAMP_W-1:0] expire_time;
  logic                          marking_enabled;

  // Control and working registers.
  rml_state_t                    state, state_next;
  logic [RML_TYPE_W-1:0]         kind;
  logic signed [RML_STAMP_W-1:0] stamp;
  logic [CW-1:0]                 count;
  logic                          dirty;
  logic [AW-1:0]                 idx;
  logic [RML_STAMP_W-1:0]        carry;
  logic                          shifting;
  logic                          unread_hit;

  // Result register.
  logic                   out_valid;
  logic                   out_unread;
  logic                   out_changed;
  logic [RML_COUNT_W-1:0] out_count;

  // List memory, one write and one read port, registered read data.
  logic [RML_STAMP_W-1:0] mem [MAX_MARKS];
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [RML_STAMP_W-1:0] mem_wdata;
  logic [AW-1:0]          mem_raddr;
  logic [RML_STAMP_W-1:0] mem_rdata;

  // Decoded conditions.
  logic accept;
  logic in_expired;
  logic start_scan;
  logic write_head;
  logic last;
  logic hit_eq;
  logic hit_gt;
  logic start_shift;
  logic scan_write;
  logic scan_end;
  logic need_tail;
  logic out_free;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expire_time     <= '0;
      marking_enabled <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_EXPIRE: expire_time     <= $signed(pwdata);
        REG_ENABLE: marking_enabled <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_EXPIRE: prdata = expire_time;
      REG_ENABLE: prdata = {{(RML_DATA_W-1){1'b0}}, marking_enabled};
      default:    prdata = '0;
    endcase
  end

  // Request decode at the accepting edge.
  assign accept     = req.valid && req.ready;
  assign in_expired = req.post_time <= expire_time;
  assign start_scan = !in_expired && (count != '0) &&
                      ((req.req_type == REQ_QUERY) ||
                       ((req.req_type == REQ_MARK) && marking_enabled));
  assign write_head = (req.req_type == REQ_TRUNC) ||
                      ((req.req_type == REQ_MARK) && marking_enabled &&
                       !in_expired && (count == '0));

  // Walk conditions. Reads always run one entry ahead of the write-back,
  // so a shifted entry is read before its slot is overwritten.
  assign last        = (CW'(idx) == count - CW'(1));
  assign hit_eq      = stamp == $signed(mem_rdata);
  assign hit_gt      = stamp > $signed(mem_rdata);
  assign start_shift = !shifting && (kind == REQ_MARK) && hit_gt;
  assign scan_write  = shifting || start_shift;
  assign scan_end    = scan_write ? last : (hit_eq || hit_gt || last);
  assign need_tail   = scan_write && (count < CW'(MAX_MARKS));
  assign out_free    = !out_valid || rsp.ready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = start_scan ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = need_tail ? ST_TAIL : ST_DONE;
        end
      end
      ST_TAIL: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory port control and channel ready.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = carry;
    mem_raddr = '0;
    req.ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        mem_we    = accept && write_head;
        mem_wdata = req.post_time;
      end
      ST_SCAN: begin
        mem_we    = scan_write;
        mem_waddr = idx;
        mem_wdata = shifting ? carry : stamp;
        mem_raddr = last ? '0 : idx + AW'(1);
      end
      ST_TAIL: begin
        mem_we    = 1'b1;
        mem_waddr = count[AW-1:0];
      end
      default: ;
    endcase
  end

  // State and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      dirty    <= 1'b0;
      shifting <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            shifting <= 1'b0;
            if (write_head) begin
              count <= CW'(1);
              dirty <= (req.req_type == REQ_MARK);
            end
          end
        end
        ST_SCAN: begin
          if (start_shift) begin
            shifting <= 1'b1;
            dirty    <= 1'b1;
          end
        end
        ST_TAIL: count <= count + CW'(1);
        default: ;
      endcase
    end
  end

  // Payload registers of the walk.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      kind       <= req.req_type;
      stamp      <= req.post_time;
      idx        <= '0;
      unread_hit <= (req.req_type == REQ_QUERY) && !in_expired && (count == '0);
    end else if (state == ST_SCAN) begin
      idx   <= idx + AW'(1);
      carry <= mem_rdata;
      if (!shifting && (kind == REQ_QUERY) && hit_gt) begin
        unread_hit <= 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_unread  <= unread_hit;
      out_changed <= dirty;
      out_count   <= RML_COUNT_W'(count);
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.unread       = out_unread;
  assign rsp.list_changed = out_changed;
  assign rsp.mark_count   = out_count;

endmodule : read_mark_list_core

`default_nettype wire

@@ rtl/rml_checker.sv @@
// Port-level checks for the read mark list block, bound to its top level.
// Depends on rml_pkg and the read_mark_list_core ports.
`default_nettype none

module rml_checker import rml_pkg::*; #(
  parameter int MAX_MARKS = 80
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   req_valid,
  input wire logic                   req_ready,
  input wire logic                   rsp_valid,
  input wire logic                   rsp_ready,
  input wire logic [RML_COUNT_W-1:0] rsp_mark_count
);

  // A result beat that is not taken stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result beat dropped while stalled");

  // Only one request is worked on at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while another is in flight");

  // Reset leaves the block idle with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_ready)
    else $error("block not idle after reset");

  // The reported count never exceeds the list capacity (unchecked above 127).
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (MAX_MARKS > 127) || (rsp_mark_count <= RML_COUNT_W'(MAX_MARKS)))
    else $error("mark count above capacity");

endmodule : rml_checker

bind read_mark_list_core rml_checker #(
  .MAX_MARKS(MAX_MARKS)
) u_rml_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_mark_count (rsp.mark_count)
);

`default_nettype wire
